### rtl/eic_pkg.sv
`default_nettype none
package eic_pkg;

	typedef enum logic [3:0] {
		OP_TICK     = 4'd0,
		OP_BRANCH   = 4'd1,
		OP_RAISE    = 4'd2,
		OP_IO_WRITE = 4'd3,
		OP_IO_READ  = 4'd4,
		OP_IRQ_SET  = 4'd5,
		OP_COP_WR   = 4'd6,
		OP_COP_RD   = 4'd7,
		OP_DATA_MAP = 4'd8
	} op_t;

	localparam logic [3:0] COP_STATUS = 4'd12;
	localparam logic [3:0] COP_CAUSE  = 4'd13;
	localparam logic [3:0] COP_EPC    = 4'd14;

	localparam logic [4:0] EXC_INT  = 5'd0;
	localparam logic [4:0] EXC_ADEL = 5'd4;

	localparam logic [31:0] VEC_BOOT  = 32'hbfc0_0180;
	localparam logic [31:0] VEC_RAM   = 32'h8000_0080;
	localparam logic [31:0] RESET_PC  = 32'hbfc0_0000;
	localparam logic [31:0] IO_ISTAT  = 32'h1f80_1070;
	localparam logic [31:0] IO_IMASK  = 32'h1f80_1074;
	localparam int          IRQ_W     = 11;
	localparam logic [31:0] PC_STEP   = 32'd4;

	function automatic logic [31:0] seg_map(input logic [31:0] a);
		logic [31:0] r;
		if (!a[31]) begin
			r = {1'b0, a[30:0]};
		end else if (!a[30]) begin
			r = {3'b000, a[28:0]};
		end else begin
			r = a;
		end
		return r;
	endfunction

	function automatic logic [31:0] push_mode(input logic [31:0] st);
		return {st[31:6], st[3:0], 2'b00};
	endfunction

	function automatic logic [31:0] set_cause(input logic [31:0] ca, input logic [4:0] code,
			input logic delay);
		return {delay, ca[30:7], code, 2'b00};
	endfunction

	function automatic logic [31:0] vector_of(input logic [31:0] st);
		return st[22] ? VEC_BOOT : VEC_RAM;
	endfunction

endpackage
`default_nettype wire

### rtl/exception_and_interrupt_control_core.sv
// Accepted input is held in the input register, its result then in the result register.
// One word per cycle unless out_ready stalls; input and result registers split the path.
// in_ready drops only while the input register is full and the result word is stalled.
// Reset (arst_n low, asynchronous): fetch_pc 0xbfc00000, following_pc 0xbfc00004,
// other PC, CP0 and IRQ state and both valid flags cleared; payload registers not reset.
`default_nettype none
module exception_and_interrupt_control_core import eic_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  opcode,
	input  wire logic [31:0] address,
	input  wire logic [31:0] value,
	input  wire logic [4:0]  exc_code,
	input  wire logic [3:0]  cop_reg,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             fetch_valid,
	output logic [31:0]      phys_addr,
	output logic             access_suppressed,
	output logic [31:0]      read_data,
	output logic             exception_taken,
	output logic             irq_pending
);

	logic              valid_s1;
	logic [3:0]        opcode_s1;
	logic [31:0]       address_s1;
	logic [31:0]       value_s1;
	logic [4:0]        exc_code_s1;
	logic [3:0]        cop_reg_s1;
	logic              advance;

	logic [31:0]       fetch_pc_q, following_pc_q, current_pc_q;
	logic              branch_seen_q, in_delay_slot_q;
	logic [31:0]       status_q, cause_q, return_pc_q;
	logic [IRQ_W-1:0]  irq_status_q, irq_mask_q;

	logic [31:0]       fetch_pc_n, following_pc_n, current_pc_n;
	logic              branch_seen_n, in_delay_slot_n;
	logic [31:0]       status_n, cause_n, return_pc_n;
	logic [IRQ_W-1:0]  irq_status_n, irq_mask_n;

	logic [31:0]       st_a, ca_a, ret_a, fetch_a, fol_a;
	logic              bs_a;

	logic              fv_n, sup_n, exc_n;
	logic [31:0]       pa_n, rd_n;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1   <= opcode;
			address_s1  <= address;
			value_s1    <= value;
			exc_code_s1 <= exc_code;
			cop_reg_s1  <= cop_reg;
		end
	end

	always_comb begin
		fetch_pc_n      = fetch_pc_q;
		following_pc_n  = following_pc_q;
		current_pc_n    = current_pc_q;
		branch_seen_n   = branch_seen_q;
		in_delay_slot_n = in_delay_slot_q;
		status_n        = status_q;
		cause_n         = cause_q;
		return_pc_n     = return_pc_q;
		irq_status_n    = irq_status_q;
		irq_mask_n      = irq_mask_q;
		fv_n  = 1'b0;
		pa_n  = '0;
		sup_n = 1'b0;
		rd_n  = '0;
		exc_n = 1'b0;

		st_a    = status_q;
		ca_a    = cause_q;
		ret_a   = return_pc_q;
		fetch_a = fetch_pc_q;
		fol_a   = following_pc_q;
		bs_a    = branch_seen_q;
		if (|fetch_pc_q[1:0]) begin
			st_a    = push_mode(status_q);
			ca_a    = set_cause(cause_q, EXC_ADEL, branch_seen_q);
			ret_a   = branch_seen_q ? fetch_pc_q - PC_STEP : fetch_pc_q;
			fetch_a = vector_of(st_a);
			fol_a   = vector_of(st_a) + PC_STEP;
			bs_a    = 1'b0;
		end

		case (opcode_s1)
			OP_TICK: begin
				fv_n            = 1'b1;
				exc_n           = |fetch_pc_q[1:0];
				current_pc_n    = fetch_a;
				fetch_pc_n      = fol_a;
				following_pc_n  = fol_a + PC_STEP;
				in_delay_slot_n = bs_a;
				branch_seen_n   = 1'b0;
				pa_n            = seg_map(fetch_a);
				status_n        = st_a;
				cause_n         = ca_a;
				return_pc_n     = ret_a;
				if (st_a[0] && |(st_a[15:8] & ca_a[15:8])) begin
					exc_n          = 1'b1;
					status_n       = push_mode(st_a);
					cause_n        = set_cause(ca_a, EXC_INT, bs_a);
					return_pc_n    = bs_a ? fetch_a - PC_STEP : fetch_a;
					fetch_pc_n     = vector_of(st_a);
					following_pc_n = vector_of(st_a) + PC_STEP;
				end
			end
			OP_BRANCH: begin
				following_pc_n = value_s1;
				branch_seen_n  = 1'b1;
			end
			OP_RAISE: begin
				exc_n          = 1'b1;
				status_n       = push_mode(status_q);
				cause_n        = set_cause(cause_q, exc_code_s1, in_delay_slot_q);
				return_pc_n    = in_delay_slot_q ? current_pc_q - PC_STEP : current_pc_q;
				fetch_pc_n     = vector_of(status_q);
				following_pc_n = vector_of(status_q) + PC_STEP;
				branch_seen_n  = 1'b0;
			end
			OP_IO_WRITE: begin
				if (address_s1 == IO_ISTAT) begin
					irq_status_n = value_s1[IRQ_W-1:0] & irq_status_q;
					cause_n[10]  = |(value_s1[IRQ_W-1:0] & irq_status_q & irq_mask_q);
				end else if (address_s1 == IO_IMASK) begin
					irq_mask_n  = value_s1[IRQ_W-1:0];
					cause_n[10] = |(value_s1[IRQ_W-1:0] & irq_status_q);
				end
			end
			OP_IO_READ: begin
				if (address_s1 == IO_ISTAT) begin
					rd_n = {{(32-IRQ_W){1'b0}}, irq_status_q};
				end else if (address_s1 == IO_IMASK) begin
					rd_n = {{(32-IRQ_W){1'b0}}, irq_mask_q};
				end
			end
			OP_IRQ_SET: begin
				irq_status_n = value_s1[IRQ_W-1:0];
				cause_n[10]  = |(value_s1[IRQ_W-1:0] & irq_mask_q);
			end
			OP_COP_WR: begin
				case (cop_reg_s1)
					COP_STATUS: status_n    = value_s1;
					COP_CAUSE:  cause_n     = value_s1;
					COP_EPC:    return_pc_n = value_s1;
					default: ;
				endcase
			end
			OP_COP_RD: begin
				case (cop_reg_s1)
					COP_STATUS: rd_n = status_q;
					COP_CAUSE:  rd_n = cause_q;
					COP_EPC:    rd_n = return_pc_q;
					default:    rd_n = '0;
				endcase
			end
			OP_DATA_MAP: begin
				pa_n  = seg_map(address_s1);
				sup_n = status_q[16];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_pc_q      <= RESET_PC;
			following_pc_q  <= RESET_PC + PC_STEP;
			current_pc_q    <= '0;
			branch_seen_q   <= 1'b0;
			in_delay_slot_q <= 1'b0;
			status_q        <= '0;
			cause_q         <= '0;
			return_pc_q     <= '0;
			irq_status_q    <= '0;
			irq_mask_q      <= '0;
			out_valid       <= 1'b0;
		end else begin
			if (advance) begin
				fetch_pc_q      <= fetch_pc_n;
				following_pc_q  <= following_pc_n;
				current_pc_q    <= current_pc_n;
				branch_seen_q   <= branch_seen_n;
				in_delay_slot_q <= in_delay_slot_n;
				status_q        <= status_n;
				cause_q         <= cause_n;
				return_pc_q     <= return_pc_n;
				irq_status_q    <= irq_status_n;
				irq_mask_q      <= irq_mask_n;
				out_valid       <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fetch_valid       <= fv_n;
			phys_addr         <= pa_n;
			access_suppressed <= sup_n;
			read_data         <= rd_n;
			exception_taken   <= exc_n;
			irq_pending       <= cause_n[10];
		end
	end

endmodule
`default_nettype wire

### rtl/eic_checker.sv
`default_nettype none
module eic_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        fetch_valid,
	input wire logic        access_suppressed,
	input wire logic [31:0] read_data,
	input wire logic        exception_taken
);

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

	a_fetch_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fetch_valid |-> read_data == 32'd0 && !access_suppressed)
		else $error("fetch word carries read or data-access fields");

	a_suppress_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && access_suppressed |-> !fetch_valid && !exception_taken
			&& read_data == 32'd0)
		else $error("suppressed access on a non-data word");

endmodule

bind exception_and_interrupt_control_core eic_checker u_eic_checker (.*);
`default_nettype wire
